>>> design/vrp_pkg.sv
// Shared types, constants and arithmetic helpers for the vertex transform.
`timescale 1ns / 1ps
package vrp_pkg;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_ANGLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_ANGLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT  = 3'd5;

    localparam int TRIG_FRAC_BITS = 14;
    // Quotient bits produced by the divider; anything larger saturates
    localparam int QUOT_W = 17;
    // Numerator magnitude, divisor and remainder compare widths
    localparam int NUM_W  = 46;
    localparam int DEN_W  = 33;
    localparam int REM_W  = DEN_W + QUOT_W;

    typedef struct packed {
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
        logic signed [15:0] depth_offset;
        logic        [14:0] near_limit;
        logic        [11:0] half_width;
        logic        [11:0] half_height;
    } vrp_cfg_t;

    // Item handed from the front end to the divider back end
    typedef struct packed {
        logic               visible;
        logic signed [34:0] num_x;
        logic signed [34:0] num_y;
        logic signed [33:0] depth;
    } vrp_item_t;

    // One restoring step: {quotient bit, new remainder}
    function automatic logic [NUM_W:0] div_step(input logic [NUM_W-1:0] rem,
                                                input logic [DEN_W-1:0] den,
                                                input int sh);
        logic [REM_W-1:0] t;
        logic [REM_W-1:0] r;
        logic             ge;
        t  = REM_W'(den) << sh;
        r  = REM_W'(rem);
        ge = (r >= t);
        return ge ? {1'b1, NUM_W'(r - t)} : {1'b0, rem};
    endfunction

    // Apply sign and clamp to 16-bit signed
    function automatic logic [15:0] sat_pix(input logic neg, input logic ovf,
                                            input logic [QUOT_W-1:0] q);
        logic [QUOT_W-1:0] nq;
        nq = -q;
        if (neg) begin
            return (ovf || q > QUOT_W'(32768)) ? 16'h8000 : nq[15:0];
        end
        return (ovf || q > QUOT_W'(32767)) ? 16'h7FFF : q[15:0];
    endfunction

endpackage

>>> design/vertex_rotate_project_viewport.sv
// Top level of the vertex rotate, project and viewport transform.
//
//   channel   handshake          payload
//   s_        s_valid/s_ready    s_vertex_x, s_vertex_y, s_vertex_z (Q3.12)
//   m_        m_valid/m_ready    m_visible, m_pixel_x, m_pixel_y
//   cfg_      cfg_wr_en          cfg_addr, cfg_wr_data (no wait, no read-back)
//
// One vertex per cycle sustained while m_ready stays high; a vertex passes the
// front registers, the queue and the back end's 17-step pipelined divider.
// Reset (synchronous, active low) clears all valids and loads register defaults.
// The back end stalls only on m_ready; the queue lets the front end keep
// taking vertices until it fills.
`timescale 1ns / 1ps
module vertex_rotate_project_viewport
    import vrp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [15:0]   s_vertex_x,
    input  logic signed [15:0]   s_vertex_y,
    input  logic signed [15:0]   s_vertex_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_visible,
    output logic signed [15:0]   m_pixel_x,
    output logic signed [15:0]   m_pixel_y
);

    vrp_cfg_t  cfg_reg;
    vrp_item_t f_item, b_item;
    logic      f_valid, f_ready, b_valid, b_ready;

    // Hold configuration registers; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cos_angle    <= 16'sd16384;
            cfg_reg.sin_angle    <= 16'sd0;
            cfg_reg.depth_offset <= 16'sd5120;
            cfg_reg.near_limit   <= 15'd41;
            cfg_reg.half_width   <= 12'd500;
            cfg_reg.half_height  <= 12'd500;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_COS_ANGLE:    cfg_reg.cos_angle    <= cfg_wr_data;
                CFG_SIN_ANGLE:    cfg_reg.sin_angle    <= cfg_wr_data;
                CFG_DEPTH_OFFSET: cfg_reg.depth_offset <= cfg_wr_data;
                CFG_NEAR_LIMIT:   cfg_reg.near_limit   <= cfg_wr_data[14:0];
                CFG_HALF_WIDTH:   cfg_reg.half_width   <= cfg_wr_data[11:0];
                CFG_HALF_HEIGHT:  cfg_reg.half_height  <= cfg_wr_data[11:0];
                default: ;
            endcase
        end
    end

    vrp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_vertex_x (s_vertex_x),
        .s_vertex_y (s_vertex_y),
        .s_vertex_z (s_vertex_z),
        .q_valid    (f_valid),
        .q_ready    (f_ready),
        .q_item     (f_item)
    );

    vrp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    vrp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (b_valid),
        .q_ready   (b_ready),
        .q_item    (b_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_visible (m_visible),
        .m_pixel_x (m_pixel_x),
        .m_pixel_y (m_pixel_y)
    );

endmodule

>>> design/vrp_front.sv
// Front end: accept vertices, rotate, offset depth and classify visibility.
`timescale 1ns / 1ps
module vrp_front
    import vrp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  vrp_cfg_t           cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_vertex_x,
    input  logic signed [15:0] s_vertex_y,
    input  logic signed [15:0] s_vertex_z,
    output logic               q_valid,
    input  logic               q_ready,
    output vrp_item_t          q_item
);

    logic               v1_reg, v2_reg;
    logic signed [31:0] xc_reg, zs_reg, xs_reg, zc_reg;
    logic signed [15:0] y_reg;
    vrp_item_t          item_reg;
    vrp_item_t          item_next;
    logic               adv;

    logic signed [32:0] rx, rz;
    logic signed [33:0] d, off_s, near_s;
    logic signed [29:0] ry;

    assign adv     = !v2_reg || q_ready;
    assign s_ready = adv;
    assign q_valid = v2_reg;
    assign q_item  = item_reg;

    // Sum the products, add depth offset, form both numerators
    always_comb begin
        rx     = 33'(xc_reg) - 33'(zs_reg);
        rz     = 33'(xs_reg) + 33'(zc_reg);
        off_s  = 34'(cfg.depth_offset) <<< TRIG_FRAC_BITS;
        near_s = $signed({5'b0, cfg.near_limit, 14'b0});
        d      = 34'(rz) + off_s;
        ry     = $signed({y_reg, 14'b0});
        item_next.visible = (d > near_s);
        item_next.depth   = d;
        item_next.num_x   = 35'(rx) + 35'(d);
        item_next.num_y   = 35'(d) - 35'(ry);
    end

    // Advance stage valids together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
        end
    end

    // Rotation products, then combined item
    always_ff @(posedge aclk) begin
        if (adv) begin
            xc_reg   <= s_vertex_x * cfg.cos_angle;
            zs_reg   <= s_vertex_z * cfg.sin_angle;
            xs_reg   <= s_vertex_x * cfg.sin_angle;
            zc_reg   <= s_vertex_z * cfg.cos_angle;
            y_reg    <= s_vertex_y;
            item_reg <= item_next;
        end
    end

endmodule

>>> design/vrp_fifo.sv
// Short item queue between the front end and the back end.
`timescale 1ns / 1ps
module vrp_fifo
    import vrp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  vrp_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output vrp_item_t out_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    vrp_item_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem[rd_ptr_reg];

    // Store pushed item
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    // Move pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/vrp_back.sv
// Back end: scale numerators, pipelined saturating divide, result register.
`timescale 1ns / 1ps
module vrp_back
    import vrp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  vrp_cfg_t           cfg,
    input  logic               q_valid,
    output logic               q_ready,
    input  vrp_item_t          q_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_visible,
    output logic signed [15:0] m_pixel_x,
    output logic signed [15:0] m_pixel_y
);

    // Stage map: scale, magnitude, QUOT_W divide steps, output
    localparam int NSTG = QUOT_W + 3;

    logic [NSTG-1:0]    vld_reg;
    logic               adv;

    logic signed [47:0] mx_reg, my_reg;
    logic [DEN_W-1:0]   md_reg;
    logic               mvis_reg;

    logic [NUM_W-1:0]   remx_reg [QUOT_W+1];
    logic [NUM_W-1:0]   remy_reg [QUOT_W+1];
    logic [QUOT_W-1:0]  qx_reg   [QUOT_W+1];
    logic [QUOT_W-1:0]  qy_reg   [QUOT_W+1];
    logic [DEN_W-1:0]   den_reg  [QUOT_W+1];
    logic               negx_reg [QUOT_W+1];
    logic               negy_reg [QUOT_W+1];
    logic               ovfx_reg [QUOT_W+1];
    logic               ovfy_reg [QUOT_W+1];
    logic               vis_reg  [QUOT_W+1];

    logic               vis_out_reg;
    logic [15:0]        px_reg, py_reg;

    logic [47:0]        absx, absy;
    logic               ngx, ngy;

    assign adv       = !vld_reg[NSTG-1] || m_ready;
    assign q_ready   = adv;
    assign m_valid   = vld_reg[NSTG-1];
    assign m_visible = vis_out_reg;
    assign m_pixel_x = px_reg;
    assign m_pixel_y = py_reg;

    // Magnitudes of the scaled numerators
    always_comb begin
        ngx  = mx_reg[47];
        ngy  = my_reg[47];
        absx = ngx ? -mx_reg : mx_reg;
        absy = ngy ? -my_reg : my_reg;
    end

    // Shift valids through the pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], q_valid};
        end
    end

    // Datapath stages
    always_ff @(posedge aclk) begin
        logic [NUM_W:0] sx, sy;
        if (adv) begin
            mx_reg   <= q_item.num_x * $signed({1'b0, cfg.half_width});
            my_reg   <= q_item.num_y * $signed({1'b0, cfg.half_height});
            md_reg   <= q_item.depth[DEN_W-1:0];
            mvis_reg <= q_item.visible;

            remx_reg[0] <= absx[NUM_W-1:0];
            remy_reg[0] <= absy[NUM_W-1:0];
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            den_reg[0]  <= md_reg;
            negx_reg[0] <= ngx;
            negy_reg[0] <= ngy;
            ovfx_reg[0] <= (REM_W'(absx[NUM_W-1:0]) >= {md_reg, {QUOT_W{1'b0}}});
            ovfy_reg[0] <= (REM_W'(absy[NUM_W-1:0]) >= {md_reg, {QUOT_W{1'b0}}});
            vis_reg[0]  <= mvis_reg;

            for (int j = 0; j < QUOT_W; j++) begin
                sx = div_step(remx_reg[j], den_reg[j], QUOT_W - 1 - j);
                sy = div_step(remy_reg[j], den_reg[j], QUOT_W - 1 - j);
                remx_reg[j+1] <= sx[NUM_W-1:0];
                remy_reg[j+1] <= sy[NUM_W-1:0];
                qx_reg[j+1]   <= {qx_reg[j][QUOT_W-2:0], sx[NUM_W]};
                qy_reg[j+1]   <= {qy_reg[j][QUOT_W-2:0], sy[NUM_W]};
                den_reg[j+1]  <= den_reg[j];
                negx_reg[j+1] <= negx_reg[j];
                negy_reg[j+1] <= negy_reg[j];
                ovfx_reg[j+1] <= ovfx_reg[j];
                ovfy_reg[j+1] <= ovfy_reg[j];
                vis_reg[j+1]  <= vis_reg[j];
            end

            // Hidden vertices report zero pixels
            vis_out_reg <= vis_reg[QUOT_W];
            px_reg <= vis_reg[QUOT_W] ?
                      sat_pix(negx_reg[QUOT_W], ovfx_reg[QUOT_W], qx_reg[QUOT_W]) : '0;
            py_reg <= vis_reg[QUOT_W] ?
                      sat_pix(negy_reg[QUOT_W], ovfy_reg[QUOT_W], qy_reg[QUOT_W]) : '0;
        end
    end

endmodule

>>> design/vrp_checker.sv
// Port-level checks for the vertex transform, bound to the top level.
`timescale 1ns / 1ps
module vrp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_visible,
    input logic signed [15:0] m_pixel_x,
    input logic signed [15:0] m_pixel_y
);

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_visible)
            && $stable(m_pixel_x) && $stable(m_pixel_y))
        else $error("stalled result changed");

    // Hidden vertices carry zero pixels
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_visible |-> m_pixel_x == 16'sd0 && m_pixel_y == 16'sd0)
        else $error("hidden vertex with nonzero pixels");

    // Reset empties the result side
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind vertex_rotate_project_viewport vrp_checker u_vrp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_visible (m_visible),
    .m_pixel_x (m_pixel_x),
    .m_pixel_y (m_pixel_y)
);
